// ===== sv/prb_pkg.sv =====
package prb_pkg;

    // field widths of the request and response words
    localparam int OP_W       = 2;
    localparam int DATA_W     = 64;
    localparam int FILL_W     = 13;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int LEN_W       = 13;
    localparam int PCT_W       = 7;

    // configuration values after reset
    localparam int LEN_RESET   = 4096;
    localparam int PCT_RESET   = 50;
    localparam int PCT_MAX     = 100;

    // operation codes carried by a request
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LENGTH  = 2'd0,
        REG_PERCENT = 2'd1,
        REG_ENABLE  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] push_word;
    } req_t;

    typedef struct packed {
        logic              out_valid;
        logic [DATA_W-1:0] out_word;
        logic              dropped_oldest;
        logic              prefilling;
        logic [FILL_W-1:0] fill_count;
    } rsp_t;

endpackage

// ===== sv/prb_ram.sv =====
module prb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds its data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/prefill_ring_buffer_drop_oldest.sv =====
// Prefilling ring buffer that overwrites its oldest entry when full.
// Requests arrive on req (valid/stall); each one gives exactly one response on
// rsp (valid/stall). A push stores a word at the tail; a pop returns the head
// word once prefill has ended and the buffer is not empty; a flush empties the
// buffer and restarts prefill. Prefill ends at the first push that finds the
// fill at or above buffer_length*pool_percent/100. Pushing into a full buffer
// drops the oldest entry and flags it. With buffering disabled a push comes
// straight back as the response word.
// The user must write configuration through cfg (valid/ready, always ready) only
// with no request in flight; unenforced. Writing length or changing enable restarts.
// One request per cycle while req_stall is low; each passes the second stage,
// then the response register. The slot memory has a registered read, so a
// pop's word arrives in the second stage; pointers and the count update at
// acceptance, so back-to-back pushes and pops see each other without forwarding.
// When the receiver stalls, the response register holds, the second stage
// fills, and then req_stall rises until the response is taken.
// Reset (rst_n low) empties the buffer, enters prefill and loads the default
// configuration; the memory contents are not cleared and need no sweep.
module prefill_ring_buffer_drop_oldest #(
    parameter int DEPTH      = 4096,
    parameter int WORD_WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  prb_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output prb_pkg::rsp_t                rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [prb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [prb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import prb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int LW = CW + PCT_W;
    localparam int PW = CW + 8;
    localparam int LEN_RESET_EFF = (LEN_RESET > DEPTH) ? DEPTH : LEN_RESET;

    // configuration state
    logic [CW-1:0]    len_reg, len_next;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic             en_reg, en_next;
    logic [LW-1:0]    limit_reg, limit_next;

    // buffer state
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] used_reg, used_next;
    logic          hold_reg, hold_next;

    // second stage and response register
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_ram_reg, s1_ram_next;
    rsp_t          s1_reg, s1_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    // memory ports
    logic                  ram_we;
    logic                  ram_re;
    logic [WORD_WIDTH-1:0] ram_rdata;

    logic accept;
    logic s1_move;
    logic cfg_write;
    logic [CW-1:0]    cfg_len;
    logic [PCT_W-1:0] cfg_pct;
    logic [CW-1:0]    mul_a;
    logic [PCT_W-1:0] mul_b;
    logic             full;
    logic             threshold_met;
    logic             restart;

    // clamp a written length into 1..DEPTH
    function automatic logic [CW-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [EW-1:0] v_ext;
        v_ext = EW'(v);
        if (v_ext == '0)
        begin
            return CW'(1);
        end
        else if (v_ext > EW'(DEPTH))
        begin
            return CW'(DEPTH);
        end
        return CW'(v_ext);
    endfunction

    // next ring position within the active length
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] len);
        logic [CW:0] n;
        n = (CW + 1)'(idx) + (CW + 1)'(1);
        return (n >= (CW + 1)'(len)) ? '0 : AW'(n);
    endfunction

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_move;
    assign accept    = req_valid && !req_stall;

    // clamped configuration values from the write data
    assign cfg_len = clamp_len(cfg_data[LEN_W-1:0]);
    assign cfg_pct = (cfg_data[PCT_W-1:0] > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                            : cfg_data[PCT_W-1:0];

    // prefill limit is length*percent, kept in a register
    assign mul_a = (cfg_index == REG_LENGTH)  ? cfg_len : len_reg;
    assign mul_b = (cfg_index == REG_PERCENT) ? cfg_pct : pct_reg;

    // fill >= floor(limit/100) is the same as 100*(fill+1) > limit
    assign threshold_met = (PW'(used_reg) + PW'(1)) * PW'(PCT_MAX) > PW'(limit_reg);
    assign full          = used_reg >= len_reg;

    // configuration writes
    always_comb
    begin
        len_next   = len_reg;
        pct_next   = pct_reg;
        en_next    = en_reg;
        limit_next = limit_reg;
        restart    = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LENGTH:
                begin
                    len_next   = cfg_len;
                    limit_next = LW'(mul_a) * LW'(mul_b);
                    restart    = 1'b1;
                end
                REG_PERCENT:
                begin
                    pct_next   = cfg_pct;
                    limit_next = LW'(mul_a) * LW'(mul_b);
                end
                REG_ENABLE:
                begin
                    en_next = cfg_data[0];
                    restart = cfg_data[0] != en_reg;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // request processing: pointer and count update plus memory access
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        used_next   = used_reg;
        hold_next   = hold_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        s1_ram_next = s1_ram_reg;
        s1_next     = s1_reg;
        if (restart)
        begin
            head_next = '0;
            tail_next = '0;
            used_next = '0;
            hold_next = 1'b1;
        end
        else if (accept)
        begin
            s1_ram_next            = 1'b0;
            s1_next.out_valid      = 1'b0;
            s1_next.out_word       = '0;
            s1_next.dropped_oldest = 1'b0;
            if (!en_reg)
            begin
                if (req.op == OP_PUSH)
                begin
                    s1_next.out_valid = 1'b1;
                    s1_next.out_word  = DATA_W'(req.push_word[WORD_WIDTH-1:0]);
                end
            end
            else
            begin
                case (req.op)
                    OP_PUSH:
                    begin
                        if (hold_reg && threshold_met)
                        begin
                            hold_next = 1'b0;
                        end
                        if (full)
                        begin
                            head_next              = advance(head_reg, len_reg);
                            s1_next.dropped_oldest = 1'b1;
                        end
                        else
                        begin
                            used_next = used_reg + CW'(1);
                        end
                        ram_we    = 1'b1;
                        tail_next = advance(tail_reg, len_reg);
                    end
                    OP_POP:
                    begin
                        if (!hold_reg && used_reg != '0)
                        begin
                            ram_re            = 1'b1;
                            s1_ram_next       = 1'b1;
                            s1_next.out_valid = 1'b1;
                            head_next         = advance(head_reg, len_reg);
                            used_next         = used_reg - CW'(1);
                        end
                    end
                    OP_FLUSH:
                    begin
                        head_next = '0;
                        tail_next = '0;
                        used_next = '0;
                        hold_next = 1'b1;
                    end
                    default:
                    begin
                        hold_next = hold_reg;
                    end
                endcase
            end
            s1_next.prefilling = en_reg && hold_next;
            s1_next.fill_count = FILL_W'(used_next);
        end
    end

    // second stage and response register control
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (s1_move)
        begin
            s1_valid_next  = 1'b0;
            rsp_valid_next = 1'b1;
            rsp_next       = s1_reg;
            if (s1_ram_reg)
            begin
                rsp_next.out_word = DATA_W'(ram_rdata);
            end
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= CW'(LEN_RESET_EFF);
            pct_reg       <= PCT_W'(PCT_RESET);
            en_reg        <= 1'b1;
            limit_reg     <= LW'(LEN_RESET_EFF * PCT_RESET);
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            hold_reg      <= 1'b1;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pct_reg       <= pct_next;
            en_reg        <= en_next;
            limit_reg     <= limit_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            used_reg      <= used_next;
            hold_reg      <= hold_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_ram_reg <= s1_ram_next;
        s1_reg     <= s1_next;
        rsp_reg    <= rsp_next;
    end

    // slot memory
    prb_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (req.push_word[WORD_WIDTH-1:0]),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/prb_checker.sv =====
module prb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_stall,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  prb_pkg::rsp_t                   rsp
);

    import prb_pkg::*;

    // a stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // a delivered word never comes while output is held for prefill
    a_word_not_prefill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_valid |-> !rsp.prefilling)
        else $error("word delivered during prefill");

    // dropping the oldest entry only happens on a stored push past prefill
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.dropped_oldest |-> !rsp.out_valid && !rsp.prefilling)
        else $error("drop flagged with a word or during prefill");

    // requests are only held off while a response waits on a stalled receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled with no blocked response");

endmodule

bind prefill_ring_buffer_drop_oldest prb_checker u_prb_checker (.*);
